@@ rtl/core/nch_pkg.sv @@
// Shared types and constants of the nibble channel histogram.
// No dependencies; every module of the block refers to it by scoped names.
package nch_pkg;

  // Sizing
  localparam int unsigned NUM_CHANNELS     = 64;
  localparam int unsigned BINS_PER_CHANNEL = 16;
  localparam int unsigned COUNT_WIDTH      = 32;
  localparam int unsigned OUT_W            = 32;
  localparam int unsigned NIBBLE_W         = 4;
  localparam int unsigned BIN_W            = $clog2(BINS_PER_CHANNEL);
  localparam int unsigned ROW_W            = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // Up to four nibbles may land in one bin per transaction
  localparam int unsigned INC_W            = 3;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);

  // Field widths of the ports
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CHANNEL_W = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POL_W     = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ       = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLEAR = 2'd2;

  // Polarization select codes
  localparam logic [POL_W-1:0] POL_ONLY0 = 2'd0;
  localparam logic [POL_W-1:0] POL_ONLY1 = 2'd1;
  localparam logic [POL_W-1:0] POL_BOTH  = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_ACC,
    KIND_READ,
    KIND_READ_CLR
  } kind_e;

  typedef logic [BINS_PER_CHANNEL-1:0][INC_W-1:0]       inc_vec_t;
  typedef logic [BINS_PER_CHANNEL-1:0][COUNT_WIDTH-1:0] row_t;

  // One decoded transaction as it travels from front to back
  typedef struct packed {
    kind_e            kind;
    logic             chan_ok;
    logic [ROW_W-1:0] row;
    logic [BIN_W-1:0] bin;
    inc_vec_t         inc;
  } entry_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

@@ rtl/core/nch_front.sv @@
// Front end: holds pol_select, accepts transactions and decodes them into
// per-bin increments or read requests. Depends on nch_pkg.
module nch_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [nch_pkg::POL_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [nch_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [nch_pkg::CHANNEL_W-1:0]      channel_i,
  input  logic [nch_pkg::BIN_W-1:0]          bin_index_i,
  input  logic [nch_pkg::BYTE_W-1:0]         pol0_byte_i,
  input  logic [nch_pkg::BYTE_W-1:0]         pol1_byte_i,
  input  nch_pkg::status_t                   status_i,
  input  logic                               push_ready_i,
  output logic                               push_valid_o,
  output nch_pkg::entry_t                    push_entry_o
);

  logic [nch_pkg::POL_W-1:0] pol_select_q, pol_select_d;

  // Configuration register
  always_comb begin
    pol_select_d = pol_select_q;
    if (cfg_we_i) begin
      pol_select_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_select_q <= nch_pkg::POL_BOTH;
    end else begin
      pol_select_q <= pol_select_d;
    end
  end

  // Hold off while the counters are being cleared or the queue is full
  assign in_ready_o = push_ready_i && !status_i.clearing;

  // Per-bin increment count from the selected nibbles
  logic [3:0]                       nib_en;
  logic [3:0][nch_pkg::NIBBLE_W-1:0] nib;
  nch_pkg::inc_vec_t                inc;

  always_comb begin
    nib[0] = pol0_byte_i[7:4];
    nib[1] = pol0_byte_i[3:0];
    nib[2] = pol1_byte_i[7:4];
    nib[3] = pol1_byte_i[3:0];
    nib_en[0] = (pol_select_q == nch_pkg::POL_ONLY0) || (pol_select_q == nch_pkg::POL_BOTH);
    nib_en[1] = nib_en[0];
    nib_en[2] = (pol_select_q == nch_pkg::POL_ONLY1) || (pol_select_q == nch_pkg::POL_BOTH);
    nib_en[3] = nib_en[2];
    for (int b = 0; b < nch_pkg::BINS_PER_CHANNEL; b++) begin
      inc[b] = '0;
      for (int k = 0; k < 4; k++) begin
        if (nib_en[k] && (nib[k] == nch_pkg::NIBBLE_W'(b))) begin
          inc[b] = inc[b] + nch_pkg::INC_W'(1);
        end
      end
    end
  end

  // Decode; unused opcode is consumed without a queue entry
  always_comb begin
    push_entry_o.chan_ok = 32'(channel_i) < nch_pkg::NUM_CHANNELS;
    push_entry_o.row     = nch_pkg::ROW_W'(channel_i);
    push_entry_o.bin     = bin_index_i;
    push_entry_o.inc     = inc;
    push_entry_o.kind    = nch_pkg::KIND_ACC;
    push_valid_o         = 1'b0;
    case (opcode_i)
      nch_pkg::OP_ACCUMULATE: begin
        push_entry_o.kind = nch_pkg::KIND_ACC;
        push_valid_o      = in_valid_i && in_ready_o;
      end
      nch_pkg::OP_READ: begin
        push_entry_o.kind = nch_pkg::KIND_READ;
        push_valid_o      = in_valid_i && in_ready_o;
      end
      nch_pkg::OP_READ_CLEAR: begin
        push_entry_o.kind = nch_pkg::KIND_READ_CLR;
        push_valid_o      = in_valid_i && in_ready_o;
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/nch_queue.sv @@
// Short queue of decoded transactions between front and back end.
// Depends on nch_pkg.
module nch_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  nch_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output nch_pkg::entry_t pop_entry_o
);

  nch_pkg::entry_t             slot_q [nch_pkg::QUEUE_DEPTH];
  logic [nch_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [nch_pkg::QPTR_W:0]    count_q, count_d;
  logic                        do_push, do_pop;

  assign push_ready_o = count_q != (nch_pkg::QPTR_W+1)'(nch_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == nch_pkg::QPTR_W'(nch_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + nch_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == nch_pkg::QPTR_W'(nch_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + nch_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (nch_pkg::QPTR_W+1)'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - (nch_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/core/nch_back.sv @@
// Back end: counter memory with one row per channel, a row read per transaction
// and written back for accumulate and read-clear, reset clearing pass and result register.
// Depends on nch_pkg.
module nch_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  nch_pkg::entry_t            pop_entry_i,
  output nch_pkg::status_t           status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [nch_pkg::OUT_W-1:0]  bin_count_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [nch_pkg::ROW_W-1:0]  clr_row_q, clr_row_d;
  logic                       out_valid_q, out_valid_d;
  logic [nch_pkg::OUT_W-1:0]  bin_count_q, bin_count_d;
  nch_pkg::entry_t            cur_q;
  nch_pkg::row_t              rd_row_q;
  nch_pkg::row_t              mem_q [nch_pkg::NUM_CHANNELS];

  nch_pkg::row_t              upd_row;
  nch_pkg::row_t              wr_data;
  logic [nch_pkg::ROW_W-1:0]  wr_addr;
  logic                       wr_en;
  logic                       pop;
  logic                       needs_out;
  logic                       can_load;
  logic                       advance;
  logic [nch_pkg::COUNT_WIDTH:0] sum [nch_pkg::BINS_PER_CHANNEL];

  assign status_o.clearing = state_q == ST_CLEAR;
  assign pop_ready_o       = state_q == ST_IDLE;
  assign pop               = pop_valid_i && pop_ready_o;
  assign needs_out         = cur_q.kind != nch_pkg::KIND_ACC;
  assign can_load          = !out_valid_q || out_ready_i;
  assign advance           = !needs_out || can_load;

  // Updated row: saturating adds for accumulate, zeroed bin for read-clear
  always_comb begin
    for (int b = 0; b < nch_pkg::BINS_PER_CHANNEL; b++) begin
      sum[b] = {1'b0, rd_row_q[b]} + (nch_pkg::COUNT_WIDTH+1)'(cur_q.inc[b]);
      if (cur_q.kind == nch_pkg::KIND_ACC) begin
        upd_row[b] = sum[b][nch_pkg::COUNT_WIDTH] ? nch_pkg::COUNT_MAX :
                     sum[b][nch_pkg::COUNT_WIDTH-1:0];
      end else if (cur_q.bin == nch_pkg::BIN_W'(b)) begin
        upd_row[b] = '0;
      end else begin
        upd_row[b] = rd_row_q[b];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_row_d   = clr_row_q;
    out_valid_d = out_valid_q && !out_ready_i;
    bin_count_d = bin_count_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q.row;
    wr_data     = upd_row;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row_q;
        wr_data = '0;
        if (clr_row_q == nch_pkg::ROW_W'(nch_pkg::NUM_CHANNELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_row_d = clr_row_q + nch_pkg::ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (advance) begin
          state_d = ST_IDLE;
          wr_en   = cur_q.chan_ok && (cur_q.kind != nch_pkg::KIND_READ);
          if (needs_out) begin
            out_valid_d = 1'b1;
            bin_count_d = cur_q.chan_ok ? nch_pkg::OUT_W'(rd_row_q[cur_q.bin]) : '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_count_q <= bin_count_d;
    if (pop) begin
      cur_q <= pop_entry_i;
    end
  end

  // Counter memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (pop) begin
      rd_row_q <= mem_q[pop_entry_i.row];
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = bin_count_q;

endmodule

@@ rtl/core/nibble_channel_histogram.sv @@
// Top level of the nibble channel histogram: front end, queue, back end.
// Depends on nch_pkg, nch_front, nch_queue and nch_back.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------
//   cfg     | cfg_we_i               | cfg_wdata_i (pol_select)
//   in      | in_valid_i / in_ready_o | opcode, channel, bin_index, pol bytes
//   out     | out_valid_o / out_ready_i | bin_count_o
//
// In the back end a transaction's counter row is read from memory as it is
// popped, then updated and, unless the transaction is a plain read, written back;
// the next one is popped only after that step. A 2-entry queue lets the front
// end take up to two transactions ahead of the back end. After reset a clearing
// pass zeroes one channel row per cycle, all NUM_CHANNELS (64) rows, with
// in_ready_o low. A result waits in the output register; the back end stalls
// only when a new result is due while that register is still held.
module nibble_channel_histogram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nch_pkg::POL_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nch_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [nch_pkg::CHANNEL_W-1:0]     channel_i,
  input  logic [nch_pkg::BIN_W-1:0]         bin_index_i,
  input  logic [nch_pkg::BYTE_W-1:0]        pol0_byte_i,
  input  logic [nch_pkg::BYTE_W-1:0]        pol1_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nch_pkg::OUT_W-1:0]         bin_count_o
);

  nch_pkg::status_t status;
  nch_pkg::entry_t  push_entry;
  nch_pkg::entry_t  pop_entry;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;

  nch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .channel_i    (channel_i),
    .bin_index_i  (bin_index_i),
    .pol0_byte_i  (pol0_byte_i),
    .pol1_byte_i  (pol1_byte_i),
    .status_i     (status),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  nch_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  nch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_count_o (bin_count_o)
  );

endmodule

@@ tb/sv/nibble_channel_histogram_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of nibble_channel_histogram: directed and random
// transactions across the channels, checked against a bin count scoreboard.
// Depends on nch_pkg and the nibble_channel_histogram RTL.
module nibble_channel_histogram_tb;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SEG_ITEMS      = 225;
  localparam int unsigned NUM_SEGS       = 6;
  localparam int unsigned HOLD_BURST     = 30;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_GAP        = 40;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned TOTAL_BINS     = nch_pkg::NUM_CHANNELS * nch_pkg::BINS_PER_CHANNEL;

  // Codes the package leaves unnamed
  localparam logic [nch_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [nch_pkg::POL_W-1:0]    POL_NONE  = 2'd3;

  typedef struct packed {
    logic [nch_pkg::OPCODE_W-1:0]  op;
    logic [nch_pkg::CHANNEL_W-1:0] chan;
    logic [nch_pkg::BIN_W-1:0]     bin;
    logic [nch_pkg::BYTE_W-1:0]    p0;
    logic [nch_pkg::BYTE_W-1:0]    p1;
  } hist_item_t;

  // Predicts bin_count results from accepted transactions
  class hist_scoreboard;
    logic [nch_pkg::COUNT_WIDTH-1:0] bin_counts [TOTAL_BINS];
    logic [nch_pkg::POL_W-1:0]       pol_sel;
    logic [nch_pkg::OUT_W-1:0]       pending_counts [$];
    int unsigned                     errors;

    function new();
      foreach (bin_counts[i]) bin_counts[i] = '0;
      pol_sel = nch_pkg::POL_BOTH;
      errors  = 0;
    endfunction

    function void set_pol(logic [nch_pkg::POL_W-1:0] v);
      pol_sel = v;
    endfunction

    // Saturating increment of the bin a nibble selects
    function void count_nibble(int unsigned chan, logic [nch_pkg::NIBBLE_W-1:0] nib);
      int unsigned idx;
      idx = chan * nch_pkg::BINS_PER_CHANNEL + nib;
      if (bin_counts[idx] != nch_pkg::COUNT_MAX) bin_counts[idx] = bin_counts[idx] + 1'b1;
    endfunction

    function void count_transaction(hist_item_t it);
      int unsigned idx;
      logic        chan_ok;
      chan_ok = it.chan < nch_pkg::NUM_CHANNELS;
      idx = it.chan * nch_pkg::BINS_PER_CHANNEL + it.bin;
      case (it.op)
        nch_pkg::OP_ACCUMULATE: begin
          if (chan_ok && (pol_sel == nch_pkg::POL_ONLY0 || pol_sel == nch_pkg::POL_BOTH)) begin
            count_nibble(it.chan, it.p0[nch_pkg::BYTE_W-1 -: nch_pkg::NIBBLE_W]);
            count_nibble(it.chan, it.p0[nch_pkg::NIBBLE_W-1:0]);
          end
          if (chan_ok && (pol_sel == nch_pkg::POL_ONLY1 || pol_sel == nch_pkg::POL_BOTH)) begin
            count_nibble(it.chan, it.p1[nch_pkg::BYTE_W-1 -: nch_pkg::NIBBLE_W]);
            count_nibble(it.chan, it.p1[nch_pkg::NIBBLE_W-1:0]);
          end
        end
        nch_pkg::OP_READ, nch_pkg::OP_READ_CLEAR: begin
          if (chan_ok) begin
            pending_counts.push_back(bin_counts[idx][nch_pkg::OUT_W-1:0]);
            if (it.op == nch_pkg::OP_READ_CLEAR) bin_counts[idx] = '0;
          end else begin
            pending_counts.push_back('0);
          end
        end
        default: ;  // unused opcode: dropped
      endcase
    endfunction

    function void check_bin_count(logic [nch_pkg::OUT_W-1:0] got);
      logic [nch_pkg::OUT_W-1:0] want;
      if (pending_counts.size() == 0) begin
        $error("bin_count: expected no result, actual %0d", got);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) begin
          $error("bin_count mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [nch_pkg::POL_W-1:0]     cfg_wdata_i = nch_pkg::POL_BOTH;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [nch_pkg::OPCODE_W-1:0]  opcode_i    = nch_pkg::OP_ACCUMULATE;
  logic [nch_pkg::CHANNEL_W-1:0] channel_i   = '0;
  logic [nch_pkg::BIN_W-1:0]     bin_index_i = '0;
  logic [nch_pkg::BYTE_W-1:0]    pol0_byte_i = '0;
  logic [nch_pkg::BYTE_W-1:0]    pol1_byte_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [nch_pkg::OUT_W-1:0]     bin_count_o;

  hist_scoreboard            sb;
  logic [nch_pkg::POL_W-1:0] cur_pol      = nch_pkg::POL_BOTH;
  int unsigned               tx_idle_pct  = 0;
  int unsigned               rx_idle_pct  = 0;
  int unsigned               rx_hold_reqs = 0;
  int unsigned               rx_hold_seen = 0;
  int unsigned               rx_hold_left = 0;
  int unsigned               cycle_count  = 0;

  nibble_channel_histogram u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .channel_i   (channel_i),
    .bin_index_i (bin_index_i),
    .pol0_byte_i (pol0_byte_i),
    .pol1_byte_i (pol1_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_count_o (bin_count_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitor: results are checked before the same edge's input is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_bin_count(bin_count_o);
      if (in_valid_i && in_ready_o) begin
        sb.count_transaction({opcode_i, channel_i, bin_index_i, pol0_byte_i, pol1_byte_i});
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen <= rx_hold_reqs;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [nch_pkg::BYTE_W-1:0] rand_sample();
    logic [nch_pkg::NIBBLE_W-1:0] nib;
    logic [nch_pkg::BYTE_W-1:0]   b;
    nib = nch_pkg::NIBBLE_W'($urandom());
    // Equal nibbles hit one bin twice
    if ($urandom_range(99) < 20) b = {nib, nib};
    else b = nch_pkg::BYTE_W'($urandom());
    return b;
  endfunction

  function automatic hist_item_t rand_item();
    hist_item_t  it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 58) it.op = nch_pkg::OP_ACCUMULATE;
    else if (pick < 76) it.op = nch_pkg::OP_READ;
    else if (pick < 93) it.op = nch_pkg::OP_READ_CLEAR;
    else it.op = OP_UNUSED;
    // Most traffic on a few channels so counts build up
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(3))
        0:       it.chan = '0;
        1:       it.chan = nch_pkg::CHANNEL_W'(1);
        2:       it.chan = nch_pkg::CHANNEL_W'(nch_pkg::NUM_CHANNELS - 2);
        default: it.chan = nch_pkg::CHANNEL_W'(nch_pkg::NUM_CHANNELS - 1);
      endcase
    end else begin
      it.chan = nch_pkg::CHANNEL_W'($urandom_range(nch_pkg::NUM_CHANNELS - 1));
    end
    it.bin = nch_pkg::BIN_W'($urandom());
    it.p0  = rand_sample();
    it.p1  = rand_sample();
    return it;
  endfunction

  // Offer one transaction after a random gap, return at the accepting edge
  task automatic send_item(hist_item_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < MAX_GAP) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i    <= it.op;
    channel_i   <= it.chan;
    bin_index_i <= it.bin;
    pol0_byte_i <= it.p0;
    pol1_byte_i <= it.p1;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_fields(logic [nch_pkg::OPCODE_W-1:0] op,
                             logic [nch_pkg::CHANNEL_W-1:0] chan,
                             logic [nch_pkg::BIN_W-1:0] bin, logic [nch_pkg::BYTE_W-1:0] p0,
                             logic [nch_pkg::BYTE_W-1:0] p1);
    send_item({op, chan, bin, p0, p1});
  endtask

  // Sender pauses until every result is in and accumulates have drained;
  // first a clock edge so the monitor has noted the last accepted transaction
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pol(logic [nch_pkg::POL_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    sb.set_pol(v);
    cur_pol = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    hist_item_t                it;
    int unsigned               done_cnt;
    logic [nch_pkg::POL_W-1:0] next_pol;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni      <= 1'b1;
    tx_idle_pct = 34;
    rx_idle_pct <= 61;

    // Directed part, pol_select at its reset value (both bytes)
    send_fields(nch_pkg::OP_READ,       6'd0,  4'd0,  8'h00, 8'h00);  // cleared at reset
    send_fields(nch_pkg::OP_READ_CLEAR, 6'd63, 4'd15, 8'h00, 8'h00);
    send_fields(nch_pkg::OP_ACCUMULATE, 6'd0,  4'd0,  8'h00, 8'h00);  // four hits on bin 0
    send_fields(nch_pkg::OP_READ,       6'd0,  4'd0,  8'h00, 8'h00);
    send_fields(nch_pkg::OP_ACCUMULATE, 6'd63, 4'd7,  8'hFF, 8'hFF);
    send_fields(nch_pkg::OP_ACCUMULATE, 6'd63, 4'd0,  8'hF0, 8'h0F);
    send_fields(nch_pkg::OP_READ_CLEAR, 6'd63, 4'd15, 8'h00, 8'h00);
    send_fields(nch_pkg::OP_READ,       6'd63, 4'd15, 8'hFF, 8'hFF);  // zero after clear
    send_fields(nch_pkg::OP_READ,       6'd63, 4'd0,  8'h00, 8'h00);
    send_fields(OP_UNUSED,              6'd0,  4'd0,  8'hFF, 8'hFF);  // dropped
    send_fields(nch_pkg::OP_READ,       6'd0,  4'd0,  8'h00, 8'h00);
    send_fields(nch_pkg::OP_ACCUMULATE, 6'd42, 4'd0,  8'hA5, 8'h5A);
    send_fields(nch_pkg::OP_READ,       6'd42, 4'd10, 8'h00, 8'h00);
    send_fields(nch_pkg::OP_READ_CLEAR, 6'd42, 4'd5,  8'h00, 8'h00);
    send_fields(nch_pkg::OP_ACCUMULATE, 6'd21, 4'd9,  8'h12, 8'h34);
    send_fields(nch_pkg::OP_READ,       6'd21, 4'd3,  8'h00, 8'h00);
    send_fields(nch_pkg::OP_READ_CLEAR, 6'd21, 4'd4,  8'h00, 8'h00);
    wait_idle();

    // Random part: one pol_select setting per segment
    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s < 2) begin
        tx_idle_pct = 34;
        rx_idle_pct <= 61;
      end else if (s < 4) begin
        tx_idle_pct = 61;
        rx_idle_pct <= 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      case (s)
        0:       next_pol = nch_pkg::POL_ONLY0;
        1:       next_pol = POL_NONE;
        2:       next_pol = nch_pkg::POL_ONLY1;
        3:       next_pol = nch_pkg::POL_BOTH;
        4:       next_pol = nch_pkg::POL_W'($urandom_range(3));
        default: next_pol = nch_pkg::POL_BOTH;
      endcase
      write_pol(next_pol);
      done_cnt = 0;

      // Long receiver hold-off while reads keep coming: block fills and stalls
      if (s == 0) begin
        rx_hold_reqs <= rx_hold_reqs + 1;
        repeat (HOLD_BURST) begin
          it = rand_item();
          it.op = nch_pkg::OP_READ;
          send_item(it);
          done_cnt++;
        end
      end

      while (done_cnt < SEG_ITEMS) begin
        it = rand_item();
        send_item(it);
        done_cnt++;
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nch_pkg.sv
rtl/core/nch_front.sv
rtl/core/nch_queue.sv
rtl/core/nch_back.sv
rtl/core/nibble_channel_histogram.sv
tb/sv/nibble_channel_histogram_tb.sv
